/* sv/lrpw_pkg.sv */
// shared types, constants and packing helpers of the line rasterizer pixel writer
`default_nettype none

package lrpw_pkg;

   localparam int COORD_BITS  = 16;
   localparam int ERR_BITS    = COORD_BITS + 3;
   localparam int CLIP_BITS   = (COORD_BITS > 15) ? COORD_BITS : 15;
   localparam int PITCH_BITS  = 18;
   localparam int PROD_BITS   = COORD_BITS + PITCH_BITS;
   localparam int XOFF_BITS   = COORD_BITS + 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // request kinds
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   // register indexes
   localparam logic [2:0] CSR_FB_BASE         = 3'd0;
   localparam logic [2:0] CSR_SCREEN_WIDTH    = 3'd1;
   localparam logic [2:0] CSR_SCREEN_HEIGHT   = 3'd2;
   localparam logic [2:0] CSR_ROW_PITCH       = 3'd3;
   localparam logic [2:0] CSR_BYTES_PER_PIXEL = 3'd4;
   localparam logic [2:0] CSR_PIXEL_ORDER     = 3'd5;

   // pixel order codes
   localparam logic ORDER_RED_FIRST  = 1'b0;
   localparam logic ORDER_BLUE_FIRST = 1'b1;

   typedef struct packed {
      logic [63:0]           fb_base;
      logic [14:0]           screen_width;
      logic [14:0]           screen_height;
      logic [PITCH_BITS-1:0] row_pitch;
      logic [2:0]            bytes_per_pixel;
      logic                  pixel_order;
   } cfg_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic [23:0]                  colour;
      logic                         last;
   } pixel_type;

   // out-of-range sizes behave as four bytes
   function automatic logic [2:0] eff_size(input logic [2:0] bpp);
      logic [2:0] size;
      if (bpp >= 3'd1 && bpp <= 3'd3) begin
         size = bpp;
      end else begin
         size = 3'd4;
      end
      return size;
   endfunction

   function automatic logic [31:0] pack_colour(input logic [23:0] colour,
                                               input logic [2:0]  size,
                                               input logic        order);
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
      logic [31:0] packed_px;
      r = colour[23:16];
      g = colour[15:8];
      b = colour[7:0];
      priority if (size == 3'd1) begin
         packed_px = {24'd0, b};
      end else if (size == 3'd2) begin
         packed_px = {16'd0, r[7:3], g[7:2], b[7:3]};
      end else if (order == ORDER_RED_FIRST) begin
         packed_px = {8'd0, b, g, r};
      end else begin
         packed_px = {8'd0, r, g, b};
      end
      return packed_px;
   endfunction

endpackage

`default_nettype wire

/* sv/lrpw_front.sv */
// front end: takes requests, holds the line walk state and steps it once per tick
`default_nettype none

module lrpw_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                accept,
   input  wire logic                                req_type,
   input  wire logic signed [lrpw_pkg::COORD_BITS-1:0] start_x,
   input  wire logic signed [lrpw_pkg::COORD_BITS-1:0] start_y,
   input  wire logic signed [lrpw_pkg::COORD_BITS-1:0] end_x,
   input  wire logic signed [lrpw_pkg::COORD_BITS-1:0] end_y,
   input  wire logic [23:0]                         colour,
   output logic                                     push,
   output lrpw_pkg::pixel_type                      pixel
);

   localparam int CB = lrpw_pkg::COORD_BITS;
   localparam int EB = lrpw_pkg::ERR_BITS;

   logic                 active_ff, active_in;
   logic signed [CB-1:0] cur_x_ff, cur_x_in;
   logic signed [CB-1:0] cur_y_ff, cur_y_in;
   logic signed [CB-1:0] tgt_x_ff, tgt_x_in;
   logic signed [CB-1:0] tgt_y_ff, tgt_y_in;
   logic signed [EB-1:0] span_x_ff, span_x_in;
   logic signed [EB-1:0] span_y_ff, span_y_in;
   logic                 step_x_neg_ff, step_x_neg_in;
   logic                 step_y_neg_ff, step_y_neg_in;
   logic signed [EB-1:0] err_ff, err_in;
   logic [23:0]          colour_ff, colour_in;

   logic signed [CB:0]   diff_x;
   logic signed [CB:0]   diff_y;
   logic signed [CB:0]   mag_x;
   logic signed [CB:0]   mag_y;
   logic signed [EB:0]   e2;
   logic                 step_x;
   logic                 step_y;
   logic                 last;
   logic                 is_load;
   logic                 is_tick;

   always_comb begin
      diff_x = (CB + 1)'(end_x) - (CB + 1)'(start_x);
      diff_y = (CB + 1)'(end_y) - (CB + 1)'(start_y);
      mag_x  = diff_x[CB] ? -diff_x : diff_x;
      mag_y  = diff_y[CB] ? -diff_y : diff_y;

      last   = (cur_x_ff == tgt_x_ff) && (cur_y_ff == tgt_y_ff);
      // both decisions use the error doubled before either update
      e2     = $signed({err_ff, 1'b0});
      step_x = e2 >= (EB + 1)'(span_y_ff);
      step_y = e2 <= (EB + 1)'(span_x_ff);

      is_load = accept && (req_type == lrpw_pkg::REQ_LOAD);
      is_tick = accept && (req_type == lrpw_pkg::REQ_TICK) && active_ff;
      push    = is_tick;

      pixel.x      = cur_x_ff;
      pixel.y      = cur_y_ff;
      pixel.colour = colour_ff;
      pixel.last   = last;
   end

   always_comb begin
      active_in     = active_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      tgt_x_in      = tgt_x_ff;
      tgt_y_in      = tgt_y_ff;
      span_x_in     = span_x_ff;
      span_y_in     = span_y_ff;
      step_x_neg_in = step_x_neg_ff;
      step_y_neg_in = step_y_neg_ff;
      err_in        = err_ff;
      colour_in     = colour_ff;
      if (is_load) begin
         active_in     = 1'b1;
         cur_x_in      = start_x;
         cur_y_in      = start_y;
         tgt_x_in      = end_x;
         tgt_y_in      = end_y;
         span_x_in     = EB'(mag_x);
         span_y_in     = -EB'(mag_y);
         step_x_neg_in = !(start_x < end_x);
         step_y_neg_in = !(start_y < end_y);
         err_in        = EB'(mag_x) - EB'(mag_y);
         colour_in     = colour;
      end else if (is_tick) begin
         if (last) begin
            active_in = 1'b0;
         end else begin
            err_in = err_ff + (step_x ? span_y_ff : '0) + (step_y ? span_x_ff : '0);
            if (step_x) begin
               cur_x_in = step_x_neg_ff ? cur_x_ff - CB'(1) : cur_x_ff + CB'(1);
            end
            if (step_y) begin
               cur_y_in = step_y_neg_ff ? cur_y_ff - CB'(1) : cur_y_ff + CB'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      tgt_x_ff      <= tgt_x_in;
      tgt_y_ff      <= tgt_y_in;
      span_x_ff     <= span_x_in;
      span_y_ff     <= span_y_in;
      step_x_neg_ff <= step_x_neg_in;
      step_y_neg_ff <= step_y_neg_in;
      err_ff        <= err_in;
      colour_ff     <= colour_in;
   end

endmodule

`default_nettype wire

/* sv/lrpw_fifo.sv */
// short pixel queue between the line walker and the address/packing back end
`default_nettype none

module lrpw_fifo (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire lrpw_pkg::pixel_type push_data,
   output logic                     full,
   input  wire logic                pop,
   output lrpw_pkg::pixel_type      pop_data,
   output logic                     empty
);

   localparam int AW = lrpw_pkg::QUEUE_AW;

   lrpw_pkg::pixel_type mem_ff [lrpw_pkg::QUEUE_DEPTH];
   logic [AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [AW:0]         count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   always_comb begin
      full     = count_ff == (AW + 1)'(lrpw_pkg::QUEUE_DEPTH);
      empty    = count_ff == '0;
      do_push  = push && !full;
      do_pop   = pop && !empty;
      pop_data = mem_ff[rd_ptr_ff];

      wr_ptr_in = do_push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (AW + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (AW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* sv/lrpw_back.sv */
// back end: clips, multiplies row offset, packs colour, forms the write beat
`default_nettype none

module lrpw_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire lrpw_pkg::cfg_type   cfg,
   input  wire logic                q_empty,
   input  wire lrpw_pkg::pixel_type q_data,
   output logic                     q_pop,
   output logic                     rsp_empty,
   input  wire logic                rsp_pop,
   output logic                     rsp_write_enable,
   output logic [63:0]              rsp_byte_address,
   output logic [31:0]              rsp_pixel_bytes,
   output logic [2:0]               rsp_byte_count,
   output logic                     rsp_last_pixel
);

   localparam int CB = lrpw_pkg::COORD_BITS;
   localparam int KB = lrpw_pkg::CLIP_BITS;
   localparam int PB = lrpw_pkg::PROD_BITS;
   localparam int XB = lrpw_pkg::XOFF_BITS;

   // stage a: clip, multiply, pack
   logic          a_valid_ff, a_valid_in;
   logic          a_on_ff, a_on_in;
   logic [PB-1:0] a_prod_ff, a_prod_in;
   logic [XB-1:0] a_xoff_ff, a_xoff_in;
   logic [31:0]   a_data_ff, a_data_in;
   logic [2:0]    a_size_ff, a_size_in;
   logic          a_last_ff, a_last_in;

   // stage b: output register
   logic          b_valid_ff, b_valid_in;
   logic          b_on_ff, b_on_in;
   logic [63:0]   b_addr_ff, b_addr_in;
   logic [31:0]   b_data_ff, b_data_in;
   logic [2:0]    b_size_ff, b_size_in;
   logic          b_last_ff, b_last_in;

   logic          b_ready;
   logic          a_move;
   logic          a_ready;
   logic [KB-1:0] x_clip;
   logic [KB-1:0] y_clip;
   logic [XB-1:0] x_u;

   always_comb begin
      b_ready = !b_valid_ff || rsp_pop;
      a_move  = a_valid_ff && b_ready;
      a_ready = !a_valid_ff || a_move;
      q_pop   = !q_empty && a_ready;

      x_clip    = KB'($unsigned(q_data.x));
      y_clip    = KB'($unsigned(q_data.y));
      x_u       = XB'($unsigned(q_data.x));
      a_size_in = lrpw_pkg::eff_size(cfg.bytes_per_pixel);
      a_on_in   = (cfg.fb_base != '0) && !q_data.x[CB-1] && !q_data.y[CB-1]
                  && (x_clip < KB'(cfg.screen_width))
                  && (y_clip < KB'(cfg.screen_height));
      a_prod_in = PB'($unsigned(q_data.y)) * PB'(cfg.row_pitch);
      unique case (a_size_in)
         3'd1:    a_xoff_in = x_u;
         3'd2:    a_xoff_in = x_u << 1;
         3'd3:    a_xoff_in = x_u + (x_u << 1);
         default: a_xoff_in = x_u << 2;
      endcase
      a_data_in  = lrpw_pkg::pack_colour(q_data.colour, a_size_in, cfg.pixel_order);
      a_last_in  = q_data.last;
      a_valid_in = q_pop ? 1'b1 : (a_move ? 1'b0 : a_valid_ff);

      // off-screen beats carry zero address and data
      b_on_in    = a_on_ff;
      b_addr_in  = a_on_ff ? cfg.fb_base + 64'(a_prod_ff) + 64'(a_xoff_ff) : '0;
      b_data_in  = a_on_ff ? a_data_ff : '0;
      b_size_in  = a_size_ff;
      b_last_in  = a_last_ff;
      b_valid_in = a_move ? 1'b1 : (rsp_pop ? 1'b0 : b_valid_ff);

      rsp_empty        = !b_valid_ff;
      rsp_write_enable = b_on_ff;
      rsp_byte_address = b_addr_ff;
      rsp_pixel_bytes  = b_data_ff;
      rsp_byte_count   = b_size_ff;
      rsp_last_pixel   = b_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         a_on_ff   <= a_on_in;
         a_prod_ff <= a_prod_in;
         a_xoff_ff <= a_xoff_in;
         a_data_ff <= a_data_in;
         a_size_ff <= a_size_in;
         a_last_ff <= a_last_in;
      end
      if (a_move) begin
         b_on_ff   <= b_on_in;
         b_addr_ff <= b_addr_in;
         b_data_ff <= b_data_in;
         b_size_ff <= b_size_in;
         b_last_ff <= b_last_in;
      end
   end

endmodule

`default_nettype wire

/* sv/line_rasterizer_pixel_writer_core.sv */
// top level of the bresenham line rasterizer with framebuffer pixel writer
//
//   channel  direction  handshake             beat
//   req_     in         push / full           load endpoints+colour, or tick
//   rsp_     out        pop / empty           one pixel write per active tick
//   csr_     in         csr_valid / ready     register index + 64-bit data
//
// one request beat per cycle is taken while req_full is low, set by the error update
// in the line walker; a pixel beat for a tick goes through the queue slot, then the
// clip/multiply stage and the address add into the output register before showing on rsp_
// loads and ticks with no line give no beat; req_full follows the 4-entry queue
// reset is synchronous: empties queue and pipeline, drops the line, sets
// registers to their defaults (32-bit, blue-first, framebuffer off)
// a stalled rsp_ side fills the pipeline, then the queue, then raises req_full
`default_nettype none

module line_rasterizer_pixel_writer_core (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // request queue side
   input  wire logic                                   req_push,
   output logic                                        req_full,
   input  wire logic                                   req_type,
   input  wire logic signed [lrpw_pkg::COORD_BITS-1:0] req_start_x,
   input  wire logic signed [lrpw_pkg::COORD_BITS-1:0] req_start_y,
   input  wire logic signed [lrpw_pkg::COORD_BITS-1:0] req_end_x,
   input  wire logic signed [lrpw_pkg::COORD_BITS-1:0] req_end_y,
   input  wire logic [23:0]                            req_colour,
   // result queue side
   output logic                                        rsp_empty,
   input  wire logic                                   rsp_pop,
   output logic                                        rsp_write_enable,
   output logic [63:0]                                 rsp_byte_address,
   output logic [31:0]                                 rsp_pixel_bytes,
   output logic [2:0]                                  rsp_byte_count,
   output logic                                        rsp_last_pixel,
   // register writes
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [2:0]                             csr_index,
   input  wire logic [63:0]                            csr_data
);

   lrpw_pkg::cfg_type   cfg_ff, cfg_in;
   lrpw_pkg::pixel_type walk_pixel;
   lrpw_pkg::pixel_type q_head;
   logic                req_accept;
   logic                q_push;
   logic                q_full;
   logic                q_empty;
   logic                q_pop;

   // register file; writes always taken, unknown indexes dropped
   always_comb begin
      csr_ready = 1'b1;
      cfg_in    = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            lrpw_pkg::CSR_FB_BASE:         cfg_in.fb_base         = csr_data;
            lrpw_pkg::CSR_SCREEN_WIDTH:    cfg_in.screen_width    = csr_data[14:0];
            lrpw_pkg::CSR_SCREEN_HEIGHT:   cfg_in.screen_height   = csr_data[14:0];
            lrpw_pkg::CSR_ROW_PITCH:
               cfg_in.row_pitch = csr_data[lrpw_pkg::PITCH_BITS-1:0];
            lrpw_pkg::CSR_BYTES_PER_PIXEL: cfg_in.bytes_per_pixel = csr_data[2:0];
            lrpw_pkg::CSR_PIXEL_ORDER:     cfg_in.pixel_order     = csr_data[0];
            default:                       cfg_in                 = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fb_base         <= '0;
         cfg_ff.screen_width    <= '0;
         cfg_ff.screen_height   <= '0;
         cfg_ff.row_pitch       <= '0;
         cfg_ff.bytes_per_pixel <= 3'd4;
         cfg_ff.pixel_order     <= lrpw_pkg::ORDER_BLUE_FIRST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // any request beat needs a free queue slot, loads included
   assign req_full   = q_full;
   assign req_accept = req_push && !q_full;

   lrpw_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .req_type (req_type),
      .start_x  (req_start_x),
      .start_y  (req_start_y),
      .end_x    (req_end_x),
      .end_y    (req_end_y),
      .colour   (req_colour),
      .push     (q_push),
      .pixel    (walk_pixel)
   );

   lrpw_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (walk_pixel),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_head),
      .empty     (q_empty)
   );

   lrpw_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_empty          (q_empty),
      .q_data           (q_head),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_write_enable (rsp_write_enable),
      .rsp_byte_address (rsp_byte_address),
      .rsp_pixel_bytes  (rsp_pixel_bytes),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_last_pixel   (rsp_last_pixel)
   );

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result side not empty after reset");

   // a suppressed write carries zero address and data
   a_off_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_write_enable) |-> (rsp_byte_address == 64'd0 &&
                                             rsp_pixel_bytes == 32'd0))
      else $error("suppressed pixel beat carries address or data");

   // byte count is always a real pixel size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_byte_count == 3'd1 || rsp_byte_count == 3'd2 ||
                      rsp_byte_count == 3'd3 || rsp_byte_count == 3'd4))
      else $error("pixel beat with invalid byte count");

   // a pixel size write lands in the register
   a_size_write: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_index == lrpw_pkg::CSR_BYTES_PER_PIXEL) |=>
      (cfg_ff.bytes_per_pixel == $past(csr_data[2:0])))
      else $error("pixel size register write lost");

endmodule

`default_nettype wire

/* sim/tb.sv */
// self-checking bench for the line rasterizer: bresenham walk, clipping, pixel packing
`default_nettype none

module tb;

   localparam int CB            = lrpw_pkg::COORD_BITS;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 8;

   // indexes past the register map, writes there must be dropped
   localparam logic [2:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [2:0] CSR_UNMAPPED_HI = 3'd7;

   typedef struct {
      logic          kind;
      logic [CB-1:0] sx;
      logic [CB-1:0] sy;
      logic [CB-1:0] ex;
      logic [CB-1:0] ey;
      logic [23:0]   colour;
   } line_req_type;

   typedef struct {
      logic        we;
      logic [63:0] addr;
      logic [31:0] data;
      logic [2:0]  count;
      logic        last;
   } pixel_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_push    = 1'b0;
   logic                 req_full;
   logic                 req_type    = lrpw_pkg::REQ_LOAD;
   logic signed [CB-1:0] req_start_x = '0;
   logic signed [CB-1:0] req_start_y = '0;
   logic signed [CB-1:0] req_end_x   = '0;
   logic signed [CB-1:0] req_end_y   = '0;
   logic [23:0]          req_colour  = '0;

   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic        rsp_write_enable;
   logic [63:0] rsp_byte_address;
   logic [31:0] rsp_pixel_bytes;
   logic [2:0]  rsp_byte_count;
   logic        rsp_last_pixel;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = lrpw_pkg::CSR_FB_BASE;
   logic [63:0] csr_data  = '0;

   line_rasterizer_pixel_writer_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_type         (req_type),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .req_colour       (req_colour),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_write_enable (rsp_write_enable),
      .rsp_byte_address (rsp_byte_address),
      .rsp_pixel_bytes  (rsp_pixel_bytes),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_last_pixel   (rsp_last_pixel),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   // register shadow, only changed while the block is idle
   logic [63:0] fb_cfg     = '0;
   int          width_cfg  = 0;
   int          height_cfg = 0;
   int          pitch_cfg  = 0;
   logic [2:0]  bpp_cfg    = 3'd4;
   logic        order_cfg  = lrpw_pkg::ORDER_BLUE_FIRST;

   // line walker shadow
   bit          drawing = 1'b0;
   int          pen_x, pen_y, goal_x, goal_y;
   int          run_x, run_y, slack;
   bit          back_x, back_y;
   logic [23:0] ink;

   line_req_type   pending_reqs[$];
   line_req_type   on_port;
   pixel_beat_type pixels_due[$];

   int fail_count     = 0;
   int loads_sent     = 0;
   int writes_due     = 0;
   int lines_ended    = 0;
   int settings_done  = 0;
   int pixels_checked = 0;
   int hold_left      = 0;
   int next_hold      = 50;
   int drv_gap        = 0;
   int drv_calm       = 0;
   int pop_gap        = 0;
   int pop_calm       = 0;
   int cycle_count;

   // mostly back to back, some short pauses, a few long ones
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // one accepted request beat: update the walker, queue the pixel it emits
   task automatic walk_request(input line_req_type rq);
      logic [2:0]     size;
      logic [31:0]    px;
      logic [63:0]    addr;
      pixel_beat_type beat;
      bit             on;
      bit             at_end;
      int             twice;
      if (rq.kind == lrpw_pkg::REQ_LOAD) begin
         pen_x   = $signed(rq.sx);
         pen_y   = $signed(rq.sy);
         goal_x  = $signed(rq.ex);
         goal_y  = $signed(rq.ey);
         run_x   = (goal_x > pen_x) ? goal_x - pen_x : pen_x - goal_x;
         run_y   = (goal_y > pen_y) ? pen_y - goal_y : goal_y - pen_y;
         back_x  = !(pen_x < goal_x);
         back_y  = !(pen_y < goal_y);
         slack   = run_x + run_y;
         ink     = rq.colour;
         drawing = 1'b1;
         loads_sent++;
      end else if (drawing) begin
         size = (bpp_cfg >= 3'd1 && bpp_cfg <= 3'd3) ? bpp_cfg : 3'd4;
         if (size == 3'd1) begin
            px = {24'd0, ink[7:0]};
         end else if (size == 3'd2) begin
            px = {16'd0, ink[23:19], ink[15:10], ink[7:3]};
         end else if (order_cfg == lrpw_pkg::ORDER_RED_FIRST) begin
            px = {8'd0, ink[7:0], ink[15:8], ink[23:16]};
         end else begin
            px = {8'd0, ink};
         end
         on = fb_cfg != 0 && pen_x >= 0 && pen_y >= 0 &&
              pen_x < width_cfg && pen_y < height_cfg;
         addr = fb_cfg + 64'(pen_y) * 64'(pitch_cfg) + 64'(pen_x) * 64'(size);
         at_end = pen_x == goal_x && pen_y == goal_y;
         beat.we    = on;
         beat.addr  = on ? addr : 64'd0;
         beat.data  = on ? px : 32'd0;
         beat.count = size;
         beat.last  = at_end;
         pixels_due.push_back(beat);
         if (on) writes_due++;
         if (at_end) begin
            drawing = 1'b0;
            lines_ended++;
         end else begin
            twice = slack * 2;
            if (twice >= run_y) begin
               slack += run_y;
               pen_x += back_x ? -1 : 1;
            end
            if (twice <= run_x) begin
               slack += run_x;
               pen_y += back_y ? -1 : 1;
            end
         end
      end
   endtask

   // queues a load and returns how many pixels its line has
   function automatic int queue_load(input int x0, input int y0, input int x1, input int y1,
                                     input logic [23:0] colour);
      line_req_type rq;
      int           dx, dy;
      rq.kind   = lrpw_pkg::REQ_LOAD;
      rq.sx     = x0[CB-1:0];
      rq.sy     = y0[CB-1:0];
      rq.ex     = x1[CB-1:0];
      rq.ey     = y1[CB-1:0];
      rq.colour = colour;
      pending_reqs.push_back(rq);
      dx = int'($signed(rq.ex)) - int'($signed(rq.sx));
      dy = int'($signed(rq.ey)) - int'($signed(rq.sy));
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      return ((dx > dy) ? dx : dy) + 1;
   endfunction

   // tick beats carry junk in the load-only fields
   task automatic queue_ticks(input int n);
      line_req_type rq;
      repeat (n) begin
         rq.kind   = lrpw_pkg::REQ_TICK;
         rq.sx     = CB'($urandom());
         rq.sy     = CB'($urandom());
         rq.ex     = CB'($urandom());
         rq.ey     = CB'($urandom());
         rq.colour = 24'($urandom());
         pending_reqs.push_back(rq);
      end
   endtask

   // start points around the screen edges so clipping gets exercised
   function automatic int near_edge(input int extent);
      case ($urandom_range(0, 2))
         0:       return int'($urandom_range(0, 16)) - 6;
         1:       return extent + int'($urandom_range(0, 12)) - 6;
         default: return $urandom_range(0, (extent > 60) ? 60 : extent);
      endcase
   endfunction

   task automatic queue_random(input int count);
      int made, r, k, len, x0, y0, x1, y1;
      made = 0;
      while (made < count) begin
         r = $urandom_range(0, 99);
         if (r < 6) begin
            // stray tick, often with no line running
            queue_ticks(1);
            made += 1;
         end else if (r < 16) begin
            // full-range endpoints, walked a little and then dropped
            k = $urandom_range(0, 6);
            void'(queue_load($urandom(), $urandom(), $urandom(), $urandom(),
                             24'($urandom())));
            queue_ticks(k);
            made += 1 + k;
         end else begin
            x0 = near_edge(width_cfg);
            y0 = near_edge(height_cfg);
            x1 = x0 + (($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(0, 30)) - 15);
            y1 = y0 + (($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(0, 30)) - 15);
            len = queue_load(x0, y0, x1, y1, 24'($urandom()));
            if (len > 64) begin
               k = $urandom_range(0, 8);
            end else if (r < 82) begin
               k = len + (($urandom_range(0, 4) == 0) ? 1 : 0);
            end else begin
               k = $urandom_range(0, len - 1);
            end
            queue_ticks(k);
            made += 1 + k;
         end
      end
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         lrpw_pkg::CSR_FB_BASE:         fb_cfg     = val;
         lrpw_pkg::CSR_SCREEN_WIDTH:    width_cfg  = int'(val[14:0]);
         lrpw_pkg::CSR_SCREEN_HEIGHT:   height_cfg = int'(val[14:0]);
         lrpw_pkg::CSR_ROW_PITCH:       pitch_cfg  = int'(val[lrpw_pkg::PITCH_BITS-1:0]);
         lrpw_pkg::CSR_BYTES_PER_PIXEL: bpp_cfg    = val[2:0];
         lrpw_pkg::CSR_PIXEL_ORDER:     order_cfg  = val[0];
         default: ;
      endcase
   endtask

   // upper bits carry junk that the registers must mask off
   task automatic set_screen(input logic [63:0] base, input int w, input int h,
                             input int pitch, input logic [2:0] bpp, input logic order);
      csr_write(lrpw_pkg::CSR_FB_BASE, base);
      csr_write(lrpw_pkg::CSR_SCREEN_WIDTH, {32'($urandom()), 17'($urandom()), 15'(w)});
      csr_write(lrpw_pkg::CSR_SCREEN_HEIGHT, {32'($urandom()), 17'($urandom()), 15'(h)});
      csr_write(lrpw_pkg::CSR_ROW_PITCH, {32'($urandom()), 14'($urandom()), 18'(pitch)});
      csr_write(lrpw_pkg::CSR_BYTES_PER_PIXEL, {32'($urandom()), 29'($urandom()), bpp});
      csr_write(lrpw_pkg::CSR_PIXEL_ORDER, {32'($urandom()), 31'($urandom()), order});
      settings_done++;
   endtask

   // everything sent, every pixel back, then let the pipe settle
   task automatic drain();
      while (pending_reqs.size() != 0 || req_push || pixels_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [63:0] base, input int w, input int h,
                            input int pitch, input logic [2:0] bpp, input logic order);
      set_screen(base, w, h, pitch, bpp, order);
      queue_random(118);
      drain();
   endtask

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 'h%0h, got 'h%0h", name, want, got);
         fail_count++;
      end
   endfunction

   // request driver: offers the oldest pending beat, holds it while full
   always @(posedge clock) begin : driver_proc
      bit taken;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         taken = req_push && !req_full;
         if (taken) begin
            walk_request(on_port);
            if (drv_calm != 0) begin
               drv_calm--;
               drv_gap = 0;
            end else begin
               drv_gap = idle_length();
               if ($urandom_range(0, 39) == 0) drv_calm = $urandom_range(20, 90);
            end
         end
         if (!req_push || taken) begin
            if (drv_gap != 0) begin
               drv_gap--;
               req_push <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               on_port = pending_reqs.pop_front();
               req_type    <= on_port.kind;
               req_start_x <= on_port.sx;
               req_start_y <= on_port.sy;
               req_end_x   <= on_port.ex;
               req_end_y   <= on_port.ey;
               req_colour  <= on_port.colour;
               req_push    <= 1'b1;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // long receiver stall while plenty is still queued, so req_full must rise
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (pixels_checked >= next_hold && pending_reqs.size() > 40) begin
         hold_left <= $urandom_range(250, 400);
         next_hold <= next_hold + 500;
      end
   end

   // pixel monitor: compares every popped beat with the oldest prediction
   always @(posedge clock) begin : monitor_proc
      pixel_beat_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (pixels_due.size() == 0) begin
               $error("pixel beat with none expected, address 'h%0h", rsp_byte_address);
               fail_count++;
            end else begin
               want = pixels_due.pop_front();
               check_field("write_enable", 64'(want.we), 64'(rsp_write_enable));
               check_field("byte_address", want.addr, rsp_byte_address);
               check_field("pixel_bytes", 64'(want.data), 64'(rsp_pixel_bytes));
               check_field("byte_count", 64'(want.count), 64'(rsp_byte_count));
               check_field("last_pixel", 64'(want.last), 64'(rsp_last_pixel));
            end
            pixels_checked <= pixels_checked + 1;
            if (pop_calm != 0) begin
               pop_calm--;
               pop_gap = 0;
            end else begin
               pop_gap = idle_length();
               if ($urandom_range(0, 39) == 0) pop_calm = $urandom_range(20, 90);
            end
         end
         if (hold_left != 0) begin
            rsp_pop <= 1'b0;
         end else if (pop_gap != 0) begin
            pop_gap--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: framebuffer off, so pixels come back unwritten
      queue_ticks(1);
      void'(queue_load(3, 4, 3, 4, 24'h123456));
      queue_ticks(2);
      drain();

      set_screen(64'h0000_0000_1000_0000, 640, 480, 2560, 3'd4, lrpw_pkg::ORDER_RED_FIRST);
      // shallow line crossing the top-left corner
      void'(queue_load(-2, -1, 5, 3, 24'hFF_FFFF));
      queue_ticks(8);
      // steep line cut short by a new load at the far corner
      void'(queue_load(10, 20, 12, 10, 24'hA5_C35A));
      queue_ticks(2);
      void'(queue_load(639, 479, 642, 477, 24'h00_FF00));
      queue_ticks(5);
      // coordinate extremes in both directions
      void'(queue_load(-32768, 32767, 32767, -32768, 24'h00_0000));
      queue_ticks(2);
      void'(queue_load(32767, -32768, -32768, 32767, 24'hFF_FFFF));
      queue_ticks(1);
      // single-point line on the origin
      void'(queue_load(0, 0, 0, 0, 24'h80_0001));
      queue_ticks(1);
      drain();

      // writes past the register map must change nothing
      csr_write(CSR_UNMAPPED_LO, {$urandom(), $urandom()});
      csr_write(CSR_UNMAPPED_HI, {$urandom(), $urandom()});

      run_phase(64'h0000_0000_8000_0000, 64, 48, 256, 3'd4, lrpw_pkg::ORDER_RED_FIRST);
      run_phase(64'h0000_0000_0000_1000, 40, 30, 40, 3'd1, lrpw_pkg::ORDER_BLUE_FIRST);
      run_phase(64'h0000_0000_2000_0000, 100, 60, 200, 3'd2, lrpw_pkg::ORDER_RED_FIRST);
      run_phase(64'hFFFF_FFFF_FFFF_FF00, 32767, 32767, 262143, 3'd3,
                lrpw_pkg::ORDER_BLUE_FIRST);
      run_phase(64'h0, 50, 50, 100, 3'd4, lrpw_pkg::ORDER_BLUE_FIRST);
      run_phase(64'h0000_0000_0000_4000, 0, 0, 0, 3'd0, lrpw_pkg::ORDER_RED_FIRST);
      run_phase(64'h1, 32, 32767, 262143, 3'd5, lrpw_pkg::ORDER_BLUE_FIRST);
      run_phase(64'h8000_0000_0000_0000, 32767, 20, 3, 3'd7, lrpw_pkg::ORDER_RED_FIRST);
      run_phase({$urandom(), $urandom()}, $urandom_range(1, 80), $urandom_range(1, 80),
                $urandom_range(0, 262143), 3'd6, 1'($urandom_range(0, 1)));
      run_phase(64'hFFFF_FFFF_FFFF_FFFF, 16, 16, 64, 3'd3, lrpw_pkg::ORDER_RED_FIRST);
      run_phase(64'h0000_0000_0000_0100, 64, 64, 256, 3'd4, lrpw_pkg::ORDER_BLUE_FIRST);
      run_phase(64'h0000_0000_0000_3000, 32, 24, 64, 3'd2, lrpw_pkg::ORDER_BLUE_FIRST);

      $display("covered %0d line loads and %0d pixel beats over %0d register settings",
               loads_sent, pixels_checked, settings_done);
      $display("%0d pixels landed on screen, %0d lines walked to their end pixel",
               writes_due, lines_ended);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
sv/lrpw_pkg.sv
sv/lrpw_front.sv
sv/lrpw_fifo.sv
sv/lrpw_back.sv
sv/line_rasterizer_pixel_writer_core.sv
sim/tb.sv
